// ----- rtl/cisb_pkg.sv -----
package cisb_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   localparam logic [REQ_TYPE_W-1:0] REQ_ADD_PLAIN = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD_RANGE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_RD_PLAIN  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_RD_RANGE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

   typedef struct packed {
      logic load;
      logic scan;
      logic rd_issue;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic bad_range;
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

// ----- rtl/cisb_if.sv -----
interface cisb_req_if;
   logic                               valid;
   logic                               ready;
   logic [cisb_pkg::REQ_TYPE_W-1:0]    req_type;
   logic                               part;
   logic                               invert;
   logic [cisb_pkg::VALUE_W-1:0]       value_lo;
   logic [cisb_pkg::VALUE_W-1:0]       value_hi;
   logic [cisb_pkg::INDEX_W-1:0]       entry_index;

   modport source (
      output valid, req_type, part, invert, value_lo, value_hi, entry_index,
      input  ready
   );
   modport sink (
      input  valid, req_type, part, invert, value_lo, value_hi, entry_index,
      output ready
   );
endinterface

interface cisb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cisb_pkg::STATUS_W-1:0]      status;
   logic [cisb_pkg::COUNT_W-1:0]       entry_count;
   logic [cisb_pkg::COUNT_W-1:0]       merged_count;
   logic [cisb_pkg::VALUE_W-1:0]       entry_lo;
   logic [cisb_pkg::VALUE_W-1:0]       entry_hi;

   modport source (
      output valid, status, entry_count, merged_count, entry_lo, entry_hi,
      input  ready
   );
   modport sink (
      input  valid, status, entry_count, merged_count, entry_lo, entry_hi,
      output ready
   );
endinterface

// ----- rtl/cisb_ctrl.sv -----
module cisb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cisb_pkg::dp_stat_type  stat,
   output cisb_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_READ   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready    = (state_ff == S_IDLE);
   assign cmd.load     = req_valid && req_ready;
   assign cmd.scan     = (state_ff == S_SCAN);
   assign cmd.rd_issue = (state_ff == S_READ);
   assign cmd.commit   = (state_ff == S_FINISH) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.is_read) state_in = S_READ;
            else if (stat.bad_range) state_in = S_FINISH;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_FINISH;
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/cisb_dpath.sv -----
module cisb_dpath #(
   parameter int PLAIN_DEPTH = 64,
   parameter int RANGE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cisb_pkg::ctrl_cmd_type            cmd,
   output cisb_pkg::dp_stat_type             stat,
   input  logic [cisb_pkg::REQ_TYPE_W-1:0]   in_req_type,
   input  logic                              in_part,
   input  logic                              in_invert,
   input  logic [cisb_pkg::VALUE_W-1:0]      in_value_lo,
   input  logic [cisb_pkg::VALUE_W-1:0]      in_value_hi,
   input  logic [cisb_pkg::INDEX_W-1:0]      in_entry_index,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [cisb_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cisb_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic [cisb_pkg::COUNT_W-1:0]      rsp_merged_count,
   output logic [cisb_pkg::VALUE_W-1:0]      rsp_entry_lo,
   output logic [cisb_pkg::VALUE_W-1:0]      rsp_entry_hi
);

   localparam int PAW  = $clog2(PLAIN_DEPTH);
   localparam int RAW  = $clog2(RANGE_DEPTH);
   localparam int PCW  = $clog2(PLAIN_DEPTH + 1);
   localparam int RCW  = $clog2(RANGE_DEPTH + 1);
   localparam int SCW  = (PCW > RCW) ? PCW : RCW;
   localparam int PMEM = 2 * (2 ** PAW);
   localparam int RMEM = 2 * (2 ** RAW);
   localparam int VW   = cisb_pkg::VALUE_W;

   function automatic logic [cisb_pkg::COUNT_W-1:0] sat7(input logic [31:0] v);
      logic [31:0] lim;
      lim = (32'd1 << cisb_pkg::COUNT_W) - 32'd1;
      return (v > lim) ? lim[cisb_pkg::COUNT_W-1:0] : v[cisb_pkg::COUNT_W-1:0];
   endfunction

   logic [VW-1:0]   plain_mem [PMEM];
   logic [2*VW-1:0] range_mem [RMEM];

   logic [cisb_pkg::REQ_TYPE_W-1:0] op_ff;
   logic                            tp_ff;
   logic [VW-1:0]                   lo_ff, hi_ff;
   logic [cisb_pkg::INDEX_W-1:0]    idx_ff;

   logic [PCW-1:0] plain_cnt_ff [2];
   logic [RCW-1:0] range_cnt_ff [2];

   logic [SCW-1:0] rd_ptr_ff, rd_ptr_in;
   logic           pend_ff, pend_in;
   logic           found_ff, found_in;
   logic [RCW-1:0] k_ff, k_in;
   logic [RCW-1:0] m_ff, m_in;
   logic [VW-1:0]  mlo_ff, mlo_in;
   logic [VW-1:0]  mhi_ff, mhi_in;

   logic [VW-1:0]   rdata_p_ff;
   logic [2*VW-1:0] rdata_r_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cisb_pkg::STATUS_W-1:0]   status_ff;
   logic [cisb_pkg::COUNT_W-1:0]    count_ff, merged_ff;
   logic [VW-1:0]                   elo_ff, ehi_ff;

   logic           is_rng;
   logic [PCW-1:0] n_p;
   logic [RCW-1:0] n_r;
   logic [SCW-1:0] n_scan;
   logic           issue;
   logic           rd_en;
   logic [PAW:0]   rd_addr_p;
   logic [RAW:0]   rd_addr_r;
   logic [VW-1:0]  slo, shi;
   logic           ovl;

   logic           wr_en_p;
   logic [PAW:0]   wr_addr_p;
   logic           wr_en_r;
   logic [RAW:0]   wr_addr_r;
   logic [2*VW-1:0] wr_data_r;

   logic                          app_p, app_r;
   logic [cisb_pkg::STATUS_W-1:0] res_status;
   logic [31:0]                   res_cnt, res_mrg;
   logic [VW-1:0]                 res_lo, res_hi;

   assign is_rng = (op_ff == cisb_pkg::REQ_ADD_RANGE);
   assign n_p    = plain_cnt_ff[tp_ff];
   assign n_r    = range_cnt_ff[tp_ff];
   assign n_scan = is_rng ? SCW'(n_r) : SCW'(n_p);
   assign issue  = cmd.scan && (rd_ptr_ff < n_scan);
   assign rd_en  = issue || cmd.rd_issue;

   assign rd_addr_p = cmd.rd_issue ? {tp_ff, PAW'(idx_ff)} : {tp_ff, rd_ptr_ff[PAW-1:0]};
   assign rd_addr_r = cmd.rd_issue ? {tp_ff, RAW'(idx_ff)} : {tp_ff, rd_ptr_ff[RAW-1:0]};

   assign slo = rdata_r_ff[VW-1:0];
   assign shi = rdata_r_ff[2*VW-1:VW];
   assign ovl = (slo <= mhi_ff) && (mlo_ff <= shi);

   assign stat.is_read   = (op_ff == cisb_pkg::REQ_RD_PLAIN) ||
                           (op_ff == cisb_pkg::REQ_RD_RANGE);
   assign stat.bad_range = is_rng && (lo_ff > hi_ff);
   assign stat.scan_done = !pend_ff && (rd_ptr_ff == n_scan);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // result of the finished item
   always_comb begin
      app_p      = 1'b0;
      app_r      = 1'b0;
      res_status = cisb_pkg::ST_OK;
      res_cnt    = 32'd0;
      res_mrg    = 32'd0;
      res_lo     = '0;
      res_hi     = '0;
      case (op_ff)
         cisb_pkg::REQ_ADD_PLAIN: begin
            res_lo  = lo_ff;
            res_hi  = lo_ff;
            res_cnt = 32'(n_p);
            if (found_ff) begin
               res_status = cisb_pkg::ST_PRESENT;
            end else if (n_p >= PCW'(PLAIN_DEPTH)) begin
               res_status = cisb_pkg::ST_FULL;
            end else begin
               app_p   = 1'b1;
               res_cnt = 32'(n_p) + 32'd1;
            end
         end
         cisb_pkg::REQ_ADD_RANGE: begin
            res_cnt = 32'(n_r);
            if (lo_ff > hi_ff) begin
               res_status = cisb_pkg::ST_BAD;
            end else if ((m_ff == '0) && (n_r >= RCW'(RANGE_DEPTH))) begin
               res_status = cisb_pkg::ST_FULL;
               res_lo     = lo_ff;
               res_hi     = hi_ff;
            end else begin
               app_r   = 1'b1;
               res_cnt = 32'(k_ff) + 32'd1;
               res_mrg = 32'(m_ff);
               res_lo  = mlo_ff;
               res_hi  = mhi_ff;
            end
         end
         cisb_pkg::REQ_RD_PLAIN: begin
            res_cnt = 32'(n_p);
            if (32'(idx_ff) < 32'(n_p)) res_lo = rdata_p_ff;
            else res_status = cisb_pkg::ST_BAD;
         end
         cisb_pkg::REQ_RD_RANGE: begin
            res_cnt = 32'(n_r);
            if (32'(idx_ff) < 32'(n_r)) begin
               res_lo = slo;
               res_hi = shi;
            end else begin
               res_status = cisb_pkg::ST_BAD;
            end
         end
         default: begin
            res_status = cisb_pkg::ST_BAD;
         end
      endcase
   end

   // table writes: compaction during the scan, append on commit
   assign wr_en_p   = cmd.commit && app_p;
   assign wr_addr_p = {tp_ff, n_p[PAW-1:0]};

   always_comb begin
      wr_en_r   = 1'b0;
      wr_addr_r = {tp_ff, k_ff[RAW-1:0]};
      wr_data_r = rdata_r_ff;
      if (cmd.commit && app_r) begin
         wr_en_r   = 1'b1;
         wr_data_r = {mhi_ff, mlo_ff};
      end else if (pend_ff && is_rng && !ovl) begin
         wr_en_r = 1'b1;
      end
   end

   // scan progress
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      pend_in   = issue;
      found_in  = found_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      mlo_in    = mlo_ff;
      mhi_in    = mhi_ff;
      if (cmd.load) begin
         rd_ptr_in = '0;
         pend_in   = 1'b0;
         found_in  = 1'b0;
         k_in      = '0;
         m_in      = '0;
         mlo_in    = in_value_lo;
         mhi_in    = in_value_hi;
      end else begin
         if (issue) rd_ptr_in = rd_ptr_ff + SCW'(1);
         if (pend_ff && !is_rng && (rdata_p_ff == lo_ff)) found_in = 1'b1;
         if (pend_ff && is_rng) begin
            if (ovl) begin
               m_in   = m_ff + RCW'(1);
               mlo_in = (slo < mlo_ff) ? slo : mlo_ff;
               mhi_in = (shi > mhi_ff) ? shi : mhi_ff;
            end else begin
               k_in = k_ff + RCW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff       <= '0;
         pend_ff         <= 1'b0;
         found_ff        <= 1'b0;
         k_ff            <= '0;
         m_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
         plain_cnt_ff[0] <= '0;
         plain_cnt_ff[1] <= '0;
         range_cnt_ff[0] <= '0;
         range_cnt_ff[1] <= '0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit && app_p) plain_cnt_ff[tp_ff] <= n_p + PCW'(1);
         if (cmd.commit && app_r) range_cnt_ff[tp_ff] <= k_ff + RCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      mlo_ff <= mlo_in;
      mhi_ff <= mhi_in;
      if (cmd.load) begin
         op_ff  <= in_req_type;
         tp_ff  <= in_req_type[1] ? in_part : (in_part ^ in_invert);
         lo_ff  <= in_value_lo;
         hi_ff  <= in_value_hi;
         idx_ff <= in_entry_index;
      end
      if (cmd.commit) begin
         status_ff <= res_status;
         count_ff  <= sat7(res_cnt);
         merged_ff <= sat7(res_mrg);
         elo_ff    <= res_lo;
         ehi_ff    <= res_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_p) plain_mem[wr_addr_p] <= lo_ff;
      if (rd_en) rdata_p_ff <= plain_mem[rd_addr_p];
   end

   always_ff @(posedge clock) begin
      if (wr_en_r) range_mem[wr_addr_r] <= wr_data_r;
      if (rd_en) rdata_r_ff <= range_mem[rd_addr_r];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_merged_count = merged_ff;
   assign rsp_entry_lo     = elo_ff;
   assign rsp_entry_hi     = ehi_ff;

endmodule

// ----- rtl/charset_interval_set_builder_core.sv -----
// Character set builder with a normal and an inverse part, each holding a table of single
// code points and a table of disjoint closed ranges in memories with one read and one write
// port. An add goes to part (part xor invert); a range add folds overlapping ranges into
// one, compacts the rest in place and appends the merged range. One word is worked on at a
// time: an add scans every stored entry of the addressed table, one stored entry per cycle
// through the table memory's read port, and a range add compacts through its write port;
// a read fetches its entry without a scan and a rejected range skips it. A finished result
// sits in an output register, so the next word is taken while it waits; a word that
// finishes while the previous result is still held waits until that one leaves.
// No clearing pass is needed after reset.
module charset_interval_set_builder_core #(
   parameter int PLAIN_DEPTH = 64,
   parameter int RANGE_DEPTH = 64
) (
   input logic         clock,
   input logic         reset,
   cisb_req_if.sink    req_bus,
   cisb_rsp_if.source  rsp_bus
);

   cisb_pkg::ctrl_cmd_type cmd;
   cisb_pkg::dp_stat_type  stat;

   cisb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cisb_dpath #(
      .PLAIN_DEPTH (PLAIN_DEPTH),
      .RANGE_DEPTH (RANGE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_req_type      (req_bus.req_type),
      .in_part          (req_bus.part),
      .in_invert        (req_bus.invert),
      .in_value_lo      (req_bus.value_lo),
      .in_value_hi      (req_bus.value_hi),
      .in_entry_index   (req_bus.entry_index),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_status       (rsp_bus.status),
      .rsp_entry_count  (rsp_bus.entry_count),
      .rsp_merged_count (rsp_bus.merged_count),
      .rsp_entry_lo     (rsp_bus.entry_lo),
      .rsp_entry_hi     (rsp_bus.entry_hi)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("word accepted while previous word still in work");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.commit))
      else $error("result shown without a commit");

   a_commit_not_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !req_bus.ready && !cmd.scan)
      else $error("commit outside finish");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && stat.scan_done) |=> !cmd.scan)
      else $error("scan continues after completion");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

   localparam int PLAIN_DEPTH = 64;
   localparam int RANGE_DEPTH = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [cisb_pkg::REQ_TYPE_W-1:0] kind;
      logic                            part;
      logic                            invert;
      logic [cisb_pkg::VALUE_W-1:0]    lo;
      logic [cisb_pkg::VALUE_W-1:0]    hi;
      logic [cisb_pkg::INDEX_W-1:0]    idx;
   } charset_word_type;

   typedef struct packed {
      logic [cisb_pkg::STATUS_W-1:0] status;
      logic [cisb_pkg::COUNT_W-1:0]  count;
      logic [cisb_pkg::COUNT_W-1:0]  merged;
      logic [cisb_pkg::VALUE_W-1:0]  lo;
      logic [cisb_pkg::VALUE_W-1:0]  hi;
   } charset_answer_type;

   logic clock = 1'b0;
   logic reset;

   cisb_req_if req_bus();
   cisb_rsp_if rsp_bus();

   charset_interval_set_builder_core #(
      .PLAIN_DEPTH(PLAIN_DEPTH),
      .RANGE_DEPTH(RANGE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // shadow copy of both parts of the character set
   logic [cisb_pkg::VALUE_W-1:0] plain_tab [2][PLAIN_DEPTH];
   logic [cisb_pkg::VALUE_W-1:0] range_lo  [2][RANGE_DEPTH];
   logic [cisb_pkg::VALUE_W-1:0] range_hi  [2][RANGE_DEPTH];
   int plain_count [2] = '{0, 0};
   int range_count [2] = '{0, 0};

   charset_answer_type charset_answers[$];
   charset_answer_type want_answer;
   int mismatches = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit gaps_on = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic charset_answer_type apply_to_charset(input charset_word_type w);
      charset_answer_type a;
      logic tgt;
      int n;
      int k;
      int m;
      logic [cisb_pkg::VALUE_W-1:0] mlo;
      logic [cisb_pkg::VALUE_W-1:0] mhi;
      tgt = w.part ^ w.invert;
      a = '0;
      case (w.kind)
         cisb_pkg::REQ_ADD_PLAIN: begin
            n = plain_count[tgt];
            a.status = cisb_pkg::ST_OK;
            a.count = cisb_pkg::COUNT_W'(n);
            a.lo = w.lo;
            a.hi = w.lo;
            for (int i = 0; i < n; i++) begin
               if (plain_tab[tgt][i] == w.lo) a.status = cisb_pkg::ST_PRESENT;
            end
            if (a.status == cisb_pkg::ST_OK) begin
               if (n >= PLAIN_DEPTH) begin
                  a.status = cisb_pkg::ST_FULL;
               end else begin
                  plain_tab[tgt][n] = w.lo;
                  plain_count[tgt] = n + 1;
                  a.count = cisb_pkg::COUNT_W'(n + 1);
               end
            end
         end
         cisb_pkg::REQ_ADD_RANGE: begin
            n = range_count[tgt];
            a.count = cisb_pkg::COUNT_W'(n);
            if (w.lo > w.hi) begin
               a.status = cisb_pkg::ST_BAD;
            end else begin
               mlo = w.lo;
               mhi = w.hi;
               m = 0;
               for (int i = 0; i < n; i++) begin
                  if (range_lo[tgt][i] <= mhi && mlo <= range_hi[tgt][i]) begin
                     if (range_lo[tgt][i] < mlo) mlo = range_lo[tgt][i];
                     if (range_hi[tgt][i] > mhi) mhi = range_hi[tgt][i];
                     m++;
                  end
               end
               if (m == 0 && n >= RANGE_DEPTH) begin
                  a.status = cisb_pkg::ST_FULL;
                  a.lo = w.lo;
                  a.hi = w.hi;
               end else begin
                  // keep disjoint ranges in order, merged range goes last
                  k = 0;
                  for (int i = 0; i < n; i++) begin
                     if (!(range_lo[tgt][i] <= mhi && mlo <= range_hi[tgt][i])) begin
                        range_lo[tgt][k] = range_lo[tgt][i];
                        range_hi[tgt][k] = range_hi[tgt][i];
                        k++;
                     end
                  end
                  if (k < RANGE_DEPTH) begin
                     range_lo[tgt][k] = mlo;
                     range_hi[tgt][k] = mhi;
                     k++;
                  end
                  range_count[tgt] = k;
                  a.status = cisb_pkg::ST_OK;
                  a.count = cisb_pkg::COUNT_W'(k);
                  a.merged = cisb_pkg::COUNT_W'(m);
                  a.lo = mlo;
                  a.hi = mhi;
               end
            end
         end
         cisb_pkg::REQ_RD_PLAIN: begin
            n = plain_count[w.part];
            a.count = cisb_pkg::COUNT_W'(n);
            if (w.idx < n) begin
               a.status = cisb_pkg::ST_OK;
               a.lo = plain_tab[w.part][w.idx];
            end else begin
               a.status = cisb_pkg::ST_BAD;
            end
         end
         default: begin
            n = range_count[w.part];
            a.count = cisb_pkg::COUNT_W'(n);
            if (w.idx < n) begin
               a.status = cisb_pkg::ST_OK;
               a.lo = range_lo[w.part][w.idx];
               a.hi = range_hi[w.part][w.idx];
            end else begin
               a.status = cisb_pkg::ST_BAD;
            end
         end
      endcase
      return a;
   endfunction

   function automatic charset_word_type make_word(
         input logic [cisb_pkg::REQ_TYPE_W-1:0] kind,
         input logic part, input logic invert,
         input logic [cisb_pkg::VALUE_W-1:0] lo,
         input logic [cisb_pkg::VALUE_W-1:0] hi,
         input logic [cisb_pkg::INDEX_W-1:0] idx);
      charset_word_type w;
      w.kind = kind;
      w.part = part;
      w.invert = invert;
      w.lo = lo;
      w.hi = hi;
      w.idx = idx;
      return w;
   endfunction

   // spread = 0 keeps ranges narrow so the range tables fill up
   function automatic charset_word_type random_word(input bit spread);
      charset_word_type w;
      int pick;
      int n;
      logic [cisb_pkg::VALUE_W-1:0] base;
      logic [cisb_pkg::VALUE_W:0] top;
      pick = $urandom_range(0, 99);
      if (pick < 30) w.kind = cisb_pkg::REQ_ADD_PLAIN;
      else if (pick < 70) w.kind = cisb_pkg::REQ_ADD_RANGE;
      else if (pick < 85) w.kind = cisb_pkg::REQ_RD_PLAIN;
      else w.kind = cisb_pkg::REQ_RD_RANGE;
      w.part = 1'($urandom_range(0, 1));
      w.invert = 1'($urandom_range(0, 1));
      w.lo = $urandom;
      w.hi = $urandom;
      w.idx = cisb_pkg::INDEX_W'($urandom_range(0, 63));
      case (w.kind)
         cisb_pkg::REQ_ADD_PLAIN: begin
            if ($urandom_range(0, 9) < 4) w.lo = $urandom_range(0, 15) * 32'h1111_1111;
         end
         cisb_pkg::REQ_ADD_RANGE: begin
            base = $urandom_range(0, 255) << 24;
            pick = $urandom_range(0, 99);
            if (!spread || pick < 80) begin
               w.lo = base + $urandom_range(0, 3000);
               w.hi = w.lo + $urandom_range(0, 2000);
            end else if (pick < 92) begin
               w.lo = base + $urandom_range(0, 3000);
               top = {1'b0, w.lo} + ($urandom_range(1, 6) << 24);
               w.hi = top[cisb_pkg::VALUE_W] ? '1 : top[cisb_pkg::VALUE_W-1:0];
            end else if (pick < 95) begin
               if ($urandom_range(0, 1)) begin
                  w.lo = '0;
                  w.hi = $urandom_range(0, 3000);
               end else begin
                  w.lo = 32'hFFFF_F000 + $urandom_range(0, 3000);
                  w.hi = '1;
               end
            end else if (pick >= 97) begin
               w.lo = $urandom | 32'h8000_0000;
               w.hi = w.lo - $urandom_range(1, 5000);
            end
         end
         cisb_pkg::REQ_RD_PLAIN: begin
            n = plain_count[w.part];
            if (n > 0 && $urandom_range(0, 1))
               w.idx = cisb_pkg::INDEX_W'($urandom_range(0, n - 1));
         end
         default: begin
            n = range_count[w.part];
            if (n > 0 && $urandom_range(0, 1))
               w.idx = cisb_pkg::INDEX_W'($urandom_range(0, n - 1));
         end
      endcase
      return w;
   endfunction

   task automatic send_word(input charset_word_type w);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= w.kind;
      req_bus.part <= w.part;
      req_bus.invert <= w.invert;
      req_bus.value_lo <= w.lo;
      req_bus.value_hi <= w.hi;
      req_bus.entry_index <= w.idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      charset_answers.push_back(apply_to_charset(w));
   endtask

   task automatic test_empty_reads();
      send_word(make_word(cisb_pkg::REQ_RD_PLAIN, 1'b0, 1'b0, '0, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_RD_RANGE, 1'b1, 1'b1, '1, '1, 6'd63));
      send_word(make_word(cisb_pkg::REQ_RD_PLAIN, 1'b1, 1'b0, '1, '0, 6'd63));
   endtask

   task automatic test_plain_adds();
      send_word(make_word(cisb_pkg::REQ_ADD_PLAIN, 1'b0, 1'b0, '0, '1, 6'd63));
      send_word(make_word(cisb_pkg::REQ_ADD_PLAIN, 1'b0, 1'b1, '1, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_PLAIN, 1'b0, 1'b0, '0, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_PLAIN, 1'b1, 1'b1, '0, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_RD_PLAIN, 1'b0, 1'b1, '0, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_RD_PLAIN, 1'b1, 1'b0, '0, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_RD_PLAIN, 1'b0, 1'b0, '0, '0, 6'd1));
   endtask

   task automatic test_range_adds();
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b0, 1'b0, 32'd0, 32'd0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b0, 1'b0, '1, '1, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b1, 1'b1, 32'd100, 32'd200, 6'd0));
      // inverted range is rejected
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b0, 1'b0, 32'd5, 32'd4, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b0, 1'b0, 32'd150, 32'd300, 6'd0));
      // touching but not overlapping
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b0, 1'b0, 32'd301, 32'd400, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b0, 1'b0, 32'd50, 32'd350, 6'd0));
      send_word(make_word(cisb_pkg::REQ_ADD_RANGE, 1'b1, 1'b0, 32'd0, '1, 6'd0));
      send_word(make_word(cisb_pkg::REQ_RD_RANGE, 1'b0, 1'b1, '0, '0, 6'd0));
      send_word(make_word(cisb_pkg::REQ_RD_RANGE, 1'b0, 1'b0, '0, '0, 6'd1));
      send_word(make_word(cisb_pkg::REQ_RD_RANGE, 1'b0, 1'b0, '0, '0, 6'd2));
      send_word(make_word(cisb_pkg::REQ_RD_RANGE, 1'b1, 1'b0, '0, '0, 6'd0));
   endtask

   task automatic test_fill_tables();
      gaps_on = 1'b1;
      repeat (600) send_word(random_word(1'b0));
   endtask

   task automatic test_mixed_traffic();
      for (int b = 0; b < 12; b++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (50) send_word(random_word(1'b1));
      end
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (300) send_word(random_word(1'b1));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (charset_answers.size() == 0) begin
            $error("result word with no request pending");
            mismatches++;
         end else begin
            want_answer = charset_answers.pop_front();
            if (rsp_bus.status !== want_answer.status) begin
               $error("status expected %0d got %0d", want_answer.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.entry_count !== want_answer.count) begin
               $error("entry_count expected %0d got %0d", want_answer.count,
                      rsp_bus.entry_count);
               mismatches++;
            end
            if (rsp_bus.merged_count !== want_answer.merged) begin
               $error("merged_count expected %0d got %0d", want_answer.merged,
                      rsp_bus.merged_count);
               mismatches++;
            end
            if (rsp_bus.entry_lo !== want_answer.lo) begin
               $error("entry_lo expected %h got %h", want_answer.lo, rsp_bus.entry_lo);
               mismatches++;
            end
            if (rsp_bus.entry_hi !== want_answer.hi) begin
               $error("entry_hi expected %h got %h", want_answer.hi, rsp_bus.entry_hi);
               mismatches++;
            end
         end
      end
      if (stall_left > 0) stall_left--;
      else if (gaps_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      rsp_bus.ready <= (stall_left == 0);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = cisb_pkg::REQ_ADD_PLAIN;
      req_bus.part = 1'b0;
      req_bus.invert = 1'b0;
      req_bus.value_lo = '0;
      req_bus.value_hi = '0;
      req_bus.entry_index = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_reads();
      test_plain_adds();
      test_range_adds();
      test_fill_tables();
      test_mixed_traffic();
      test_back_to_back();
      req_bus.valid <= 1'b0;
      while (charset_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && charset_answers.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
